>>> rtl/fk_pkg.sv
`default_nettype none
package fk_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int NLANE = 6;
    localparam int SHW = $clog2(CORDIC_STAGES);
    localparam int WW = 36;
    localparam int AW = 39;

    typedef logic signed [WW-1:0] t_w;
    typedef logic signed [AW-1:0] t_ang;
    typedef logic signed [31:0] t_q;

    localparam t_ang PI_Q32      = 39'sd13493037705;
    localparam t_ang TWO_PI_Q32  = 39'sd26986075409;
    localparam t_ang HALF_PI_Q32 = 39'sd6746518852;
    localparam t_ang PI3_Q32     = PI_Q32 + TWO_PI_Q32;
    localparam t_ang PI5_Q32     = PI_Q32 + 39'sd2 * TWO_PI_Q32;
    localparam t_ang TWO_PI2_Q32 = 39'sd2 * TWO_PI_Q32;
    localparam t_ang TWO_PI3_Q32 = 39'sd3 * TWO_PI_Q32;
    localparam t_w QUARTER_PI_Q32 = 36'sd3373259426;
    localparam t_w GAIN_Q32       = 36'sd2608131496;
    localparam t_w ONE_Q30        = 36'sd1073741824;

    // lane order of the sine/cosine chain
    localparam int LN_1  = 0;
    localparam int LN_2  = 1;
    localparam int LN_23 = 2;
    localparam int LN_4  = 3;
    localparam int LN_5  = 4;
    localparam int LN_6  = 5;

    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;

    localparam logic [1:0] CFG_SHOULDER = 2'd0;
    localparam logic [1:0] CFG_UPPER    = 2'd1;
    localparam logic [1:0] CFG_FOREARM  = 2'd2;
    localparam logic [1:0] CFG_TOOL     = 2'd3;

    typedef struct packed {
        t_w   x;
        t_w   y;
        t_w   z;
        logic neg;
    } t_lane;

    typedef t_lane [NLANE-1:0] t_lanes;

    typedef struct packed {
        logic vld;
        logic elbow_dn;
        logic wrist_flip;
    } t_meta;

    typedef struct packed {
        t_q c0;
        t_q c1;
        t_q c2;
        t_q pos;
    } t_row;

    typedef t_row [2:0] t_rows;

    // unsigned quotient by shift and subtract; elaboration only
    function automatic longint udiv_c(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((n >>> b) & 64'sd1);
            q = q <<< 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // arctan(2^-i) in Q.32 from its power series in Q.60; elaboration only
    function automatic t_w atan_q32(input int i);
        longint sum;
        longint t;
        sum = 0;
        if (i == 0) begin
            return QUARTER_PI_Q32;
        end
        for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
            t = udiv_c(longint'(64'd1 << (60 - (2 * k + 1) * i)), longint'(2 * k + 1));
            sum = ((k & 1) == 1) ? sum - t : sum + t;
        end
        return t_w'((sum + (64'sd1 <<< 27)) >>> 28);
    endfunction

    // product rescaled by 2^-30, round half up
    function automatic t_w mulq(input t_w a, input t_w b);
        logic signed [2*WW-1:0] p;
        p = a * b;
        p = p + (72'sd1 <<< 29);
        return t_w'(p >>> 30);
    endfunction

    function automatic t_q sat32(input t_w v);
        if (v > t_w'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (v < -t_w'(36'sh080000000)) begin
            return 32'sh80000000;
        end
        return t_q'(v);
    endfunction

    // CORDIC Q.32 result to Q1.30, clamped to [-1, 1], quadrant sign applied
    function automatic t_q round_cs(input t_w v, input logic neg);
        t_w r;
        r = (v + 36'sd2) >>> 2;
        if (r > ONE_Q30) begin
            r = ONE_Q30;
        end else if (r < -ONE_Q30) begin
            r = -ONE_Q30;
        end
        if (neg) begin
            r = -r;
        end
        return t_q'(r);
    endfunction

endpackage
`default_nettype wire

>>> rtl/six_axis_forward_kinematics.sv
`default_nettype none
// Forward kinematics of a six-joint Z-X-X-Z-X-Z arm. A request (six Q3.28
// joint angles) is taken at a clock edge with start high and busy low; busy
// then goes high until the GAP countdown runs out, so a new request can be
// taken while earlier ones are still in flight; the pace is set by the three
// results sharing one result port. Each request yields three results, rows
// x, y and z in that order on consecutive cycles, each shown for exactly
// one cycle with o_strobe high; o_last_row marks row z. The receiver cannot
// stall: results must be captured when strobed. The accepting edge loads
// the first of two angle reduction stages; then follow one chain cell per
// CORDIC iteration, five product stages, and the result bank, which loads
// on the edge that raises row x. Link lengths are written through i_cfg_wr /
// i_cfg_addr / i_cfg_data, take effect at once, and must only change while
// no request is in flight. No clearing pass.
module six_axis_forward_kinematics (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_cfg_wr,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_data,
    input  wire  [31:0] i_joint_angle_1,
    input  wire  [31:0] i_joint_angle_2,
    input  wire  [31:0] i_joint_angle_3,
    input  wire  [31:0] i_joint_angle_4,
    input  wire  [31:0] i_joint_angle_5,
    input  wire  [31:0] i_joint_angle_6,
    output logic        o_strobe,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_rot_col0,
    output logic [31:0] o_rot_col1,
    output logic [31:0] o_rot_col2,
    output logic [31:0] o_position,
    output logic [2:0]  o_pose_flags,
    output logic        o_last_row
);

    localparam logic [1:0] GAP = 2'd2;

    logic [1:0]  r_gap;
    logic        w_accept;
    fk_pkg::t_q  r_l1, r_l2, r_l3, r_l6;

    fk_pkg::t_meta  w_meta  [fk_pkg::CORDIC_STAGES+1];
    fk_pkg::t_lanes w_lanes [fk_pkg::CORDIC_STAGES+1];

    logic          w_bank_vld;
    logic [2:0]    w_flags;
    fk_pkg::t_rows w_rows;
    fk_pkg::t_row  w_sel;

    logic        r_act;
    logic [1:0]  r_row;

    // request pacing: busy counts down from GAP after each accepted request
    assign w_accept = start && !busy;
    assign busy     = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else if (w_accept) begin
            r_gap <= GAP;
        end else if (r_gap != 2'd0) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    // link length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= '0;
            r_l2 <= '0;
            r_l3 <= '0;
            r_l6 <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_addr)
                fk_pkg::CFG_SHOULDER: r_l1 <= i_cfg_data;
                fk_pkg::CFG_UPPER:    r_l2 <= i_cfg_data;
                fk_pkg::CFG_FOREARM:  r_l3 <= i_cfg_data;
                fk_pkg::CFG_TOOL:     r_l6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // reduce angles, preload CORDIC vectors
    fk_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_j1    (i_joint_angle_1),
        .i_j2    (i_joint_angle_2),
        .i_j3    (i_joint_angle_3),
        .i_j4    (i_joint_angle_4),
        .i_j5    (i_joint_angle_5),
        .i_j6    (i_joint_angle_6),
        .o_meta  (w_meta[0]),
        .o_lanes (w_lanes[0])
    );

    // chain of CORDIC cells, one iteration each, six angles per cell
    for (genvar g = 0; g < fk_pkg::CORDIC_STAGES; g++) begin : g_cell
        localparam fk_pkg::t_w ATAN = fk_pkg::atan_q32(g);
        fk_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (fk_pkg::SHW'(g)),
            .i_atan  (ATAN),
            .i_meta  (w_meta[g]),
            .i_lanes (w_lanes[g]),
            .o_meta  (w_meta[g+1]),
            .o_lanes (w_lanes[g+1])
        );
    end

    // rotation matrix and position
    fk_pose u_pose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (w_meta[fk_pkg::CORDIC_STAGES]),
        .i_lanes (w_lanes[fk_pkg::CORDIC_STAGES]),
        .i_l1    (r_l1),
        .i_l2    (r_l2),
        .i_l3    (r_l3),
        .i_l6    (r_l6),
        .o_vld   (w_bank_vld),
        .o_flags (w_flags),
        .o_rows  (w_rows)
    );

    // row sequencer: starts on the edge that loads the bank, which then
    // holds for the three rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_row <= fk_pkg::ROW_X;
        end else if (w_bank_vld) begin
            r_act <= 1'b1;
            r_row <= fk_pkg::ROW_X;
        end else if (r_act) begin
            if (r_row == fk_pkg::ROW_Z) begin
                r_act <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_comb begin
        case (r_row)
            fk_pkg::ROW_X: w_sel = w_rows[0];
            fk_pkg::ROW_Y: w_sel = w_rows[1];
            default:       w_sel = w_rows[2];
        endcase
    end

    assign o_strobe     = r_act;
    assign o_row_index  = r_row;
    assign o_rot_col0   = w_sel.c0;
    assign o_rot_col1   = w_sel.c1;
    assign o_rot_col2   = w_sel.c2;
    assign o_position   = w_sel.pos;
    assign o_pose_flags = w_flags;
    assign o_last_row   = r_act && (r_row == fk_pkg::ROW_Z);

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low right after a request");

    a_row_x_to_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_row_index == fk_pkg::ROW_X) |=>
        (o_strobe && o_row_index == fk_pkg::ROW_Y))
        else $error("row y did not follow row x");

    a_row_y_to_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_row_index == fk_pkg::ROW_Y) |=>
        (o_strobe && o_row_index == fk_pkg::ROW_Z))
        else $error("row z did not follow row y");

    a_last_is_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_row |-> (o_strobe && o_row_index == fk_pkg::ROW_Z))
        else $error("last row flag off row z");

endmodule
`default_nettype wire

>>> rtl/fk_prep.sv
`default_nettype none
module fk_prep (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_vld,
    input  fk_pkg::t_q          i_j1,
    input  fk_pkg::t_q          i_j2,
    input  fk_pkg::t_q          i_j3,
    input  fk_pkg::t_q          i_j4,
    input  fk_pkg::t_q          i_j5,
    input  fk_pkg::t_q          i_j6,
    output fk_pkg::t_meta       o_meta,
    output fk_pkg::t_lanes      o_lanes
);

    fk_pkg::t_ang  w_a   [fk_pkg::NLANE];
    fk_pkg::t_ang  n_red [fk_pkg::NLANE];
    fk_pkg::t_ang  r_red [fk_pkg::NLANE];
    fk_pkg::t_meta r_meta_a;
    fk_pkg::t_meta r_meta;
    fk_pkg::t_lanes r_lanes;
    fk_pkg::t_lanes n_lanes;

    // angles to Q.32
    assign w_a[fk_pkg::LN_1]  = fk_pkg::t_ang'(i_j1) <<< 4;
    assign w_a[fk_pkg::LN_2]  = fk_pkg::t_ang'(i_j2) <<< 4;
    assign w_a[fk_pkg::LN_23] = (fk_pkg::t_ang'(i_j2) + fk_pkg::t_ang'(i_j3)) <<< 4;
    assign w_a[fk_pkg::LN_4]  = fk_pkg::t_ang'(i_j4) <<< 4;
    assign w_a[fk_pkg::LN_5]  = fk_pkg::t_ang'(i_j5) <<< 4;
    assign w_a[fk_pkg::LN_6]  = fk_pkg::t_ang'(i_j6) <<< 4;

    // bring into [-pi, pi]: at most three turns off
    always_comb begin
        for (int k = 0; k < fk_pkg::NLANE; k++) begin
            if (w_a[k] > fk_pkg::PI5_Q32) begin
                n_red[k] = w_a[k] - fk_pkg::TWO_PI3_Q32;
            end else if (w_a[k] > fk_pkg::PI3_Q32) begin
                n_red[k] = w_a[k] - fk_pkg::TWO_PI2_Q32;
            end else if (w_a[k] > fk_pkg::PI_Q32) begin
                n_red[k] = w_a[k] - fk_pkg::TWO_PI_Q32;
            end else if (w_a[k] < -fk_pkg::PI5_Q32) begin
                n_red[k] = w_a[k] + fk_pkg::TWO_PI3_Q32;
            end else if (w_a[k] < -fk_pkg::PI3_Q32) begin
                n_red[k] = w_a[k] + fk_pkg::TWO_PI2_Q32;
            end else if (w_a[k] < -fk_pkg::PI_Q32) begin
                n_red[k] = w_a[k] + fk_pkg::TWO_PI_Q32;
            end else begin
                n_red[k] = w_a[k];
            end
        end
    end

    // fold into [-pi/2, pi/2], load CORDIC start vector
    always_comb begin
        for (int k = 0; k < fk_pkg::NLANE; k++) begin
            n_lanes[k].x = fk_pkg::GAIN_Q32;
            n_lanes[k].y = '0;
            if (r_red[k] > fk_pkg::HALF_PI_Q32) begin
                n_lanes[k].z   = fk_pkg::t_w'(r_red[k] - fk_pkg::PI_Q32);
                n_lanes[k].neg = 1'b1;
            end else if (r_red[k] < -fk_pkg::HALF_PI_Q32) begin
                n_lanes[k].z   = fk_pkg::t_w'(r_red[k] + fk_pkg::PI_Q32);
                n_lanes[k].neg = 1'b1;
            end else begin
                n_lanes[k].z   = fk_pkg::t_w'(r_red[k]);
                n_lanes[k].neg = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_a <= '0;
            r_meta   <= '0;
        end else begin
            r_meta_a <= '{vld: i_vld, elbow_dn: i_j3[31], wrist_flip: i_j5[31]};
            r_meta   <= r_meta_a;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fk_pkg::NLANE; k++) begin
            r_red[k] <= n_red[k];
        end
        r_lanes <= n_lanes;
    end

    assign o_meta  = r_meta;
    assign o_lanes = r_lanes;

endmodule
`default_nettype wire

>>> rtl/fk_cordic_cell.sv
`default_nettype none
module fk_cordic_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [fk_pkg::SHW-1:0]    i_shift,
    input  fk_pkg::t_w               i_atan,
    input  fk_pkg::t_meta            i_meta,
    input  fk_pkg::t_lanes           i_lanes,
    output fk_pkg::t_meta            o_meta,
    output fk_pkg::t_lanes           o_lanes
);

    fk_pkg::t_lanes n_lanes;
    fk_pkg::t_lanes r_lanes;
    fk_pkg::t_meta  r_meta;

    // one rotation step, all six lanes side by side
    always_comb begin
        for (int k = 0; k < fk_pkg::NLANE; k++) begin
            n_lanes[k].neg = i_lanes[k].neg;
            if (i_lanes[k].z >= 0) begin
                n_lanes[k].x = i_lanes[k].x - (i_lanes[k].y >>> i_shift);
                n_lanes[k].y = i_lanes[k].y + (i_lanes[k].x >>> i_shift);
                n_lanes[k].z = i_lanes[k].z - i_atan;
            end else begin
                n_lanes[k].x = i_lanes[k].x + (i_lanes[k].y >>> i_shift);
                n_lanes[k].y = i_lanes[k].y - (i_lanes[k].x >>> i_shift);
                n_lanes[k].z = i_lanes[k].z + i_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
    end

    assign o_meta  = r_meta;
    assign o_lanes = r_lanes;

endmodule
`default_nettype wire

>>> rtl/fk_pose.sv
`default_nettype none
module fk_pose (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  fk_pkg::t_meta    i_meta,
    input  fk_pkg::t_lanes   i_lanes,
    input  fk_pkg::t_q       i_l1,
    input  fk_pkg::t_q       i_l2,
    input  fk_pkg::t_q       i_l3,
    input  fk_pkg::t_q       i_l6,
    output logic             o_vld,
    output logic [2:0]       o_flags,
    output fk_pkg::t_rows    o_rows
);

    fk_pkg::t_w r0_c [fk_pkg::NLANE];
    fk_pkg::t_w r0_s [fk_pkg::NLANE];
    fk_pkg::t_meta r0_meta, r1_meta, r2_meta, r3_meta, r4_meta;
    fk_pkg::t_w c1, s1, c2, s2, c23, s23, c4, s4, c5, s5, c6, s6;

    fk_pkg::t_w r1_s5c6, r1_s5s6, r1_c4s5, r1_s4s5, r1_c1c23, r1_c1s23, r1_s1c23, r1_s1s23;
    fk_pkg::t_w r1_s4c5, r1_c4c5, r1_c4c6, r1_s4c6, r1_c4s6, r1_s4s6;
    fk_pkg::t_w r1_s2l2, r1_c2l2, r1_c23l3, r1_s23l3;
    fk_pkg::t_w r1_c1, r1_s1, r1_c23, r1_s23, r1_c5, r1_c6, r1_s6;

    fk_pkg::t_w r2_u1, r2_u2, r2_u3, r2_u4;
    fk_pkg::t_w r2_p02a, r2_p02b, r2_p02c, r2_p12a, r2_p12b, r2_p12c, r2_p22a, r2_p22b;
    fk_pkg::t_w r2_dwv, r2_dwh;
    fk_pkg::t_w r2_c4c6, r2_s4c6, r2_c4s6, r2_s4s6;
    fk_pkg::t_w r2_s1c23, r2_c1c23, r2_s1s23, r2_c1s23, r2_s5s6, r2_s5c6;
    fk_pkg::t_w r2_c1, r2_s1, r2_s23, r2_c23;

    fk_pkg::t_w r3_b0, r3_a0, r3_b1, r3_a1, r3_m02, r3_m12, r3_m22, r3_ps0, r3_ps1, r3_dwv;
    logic       r3_wb;
    fk_pkg::t_w r3_s1c23, r3_c1c23, r3_s1s23, r3_c1s23, r3_s5s6, r3_s5c6;
    fk_pkg::t_w r3_c1, r3_s1, r3_s23, r3_c23;

    fk_pkg::t_w r4_q00a, r4_q00b, r4_q00c, r4_q10a, r4_q10b, r4_q10c, r4_q20a, r4_q20b;
    fk_pkg::t_w r4_q01a, r4_q01b, r4_q01c, r4_q11a, r4_q11b, r4_q11c, r4_q21a, r4_q21b;
    fk_pkg::t_w r4_r0, r4_r1, r4_r2, r4_ps0, r4_ps1, r4_dwv, r4_m02, r4_m12, r4_m22;
    logic       r4_wb;

    logic [2:0]    r5_flags;
    fk_pkg::t_rows r5_rows;

    assign c1  = r0_c[fk_pkg::LN_1];
    assign s1  = r0_s[fk_pkg::LN_1];
    assign c2  = r0_c[fk_pkg::LN_2];
    assign s2  = r0_s[fk_pkg::LN_2];
    assign c23 = r0_c[fk_pkg::LN_23];
    assign s23 = r0_s[fk_pkg::LN_23];
    assign c4  = r0_c[fk_pkg::LN_4];
    assign s4  = r0_s[fk_pkg::LN_4];
    assign c5  = r0_c[fk_pkg::LN_5];
    assign s5  = r0_s[fk_pkg::LN_5];
    assign c6  = r0_c[fk_pkg::LN_6];
    assign s6  = r0_s[fk_pkg::LN_6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_meta <= '0;
            r1_meta <= '0;
            r2_meta <= '0;
            r3_meta <= '0;
            r4_meta <= '0;
        end else begin
            r0_meta <= i_meta;
            r1_meta <= r0_meta;
            r2_meta <= r1_meta;
            r3_meta <= r2_meta;
            r4_meta <= r3_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        // S0: round CORDIC results
        for (int k = 0; k < fk_pkg::NLANE; k++) begin
            r0_c[k] <= fk_pkg::t_w'(fk_pkg::round_cs(i_lanes[k].x, i_lanes[k].neg));
            r0_s[k] <= fk_pkg::t_w'(fk_pkg::round_cs(i_lanes[k].y, i_lanes[k].neg));
        end

        // S1: first products
        r1_s5c6  <= fk_pkg::mulq(s5, c6);
        r1_s5s6  <= fk_pkg::mulq(s5, s6);
        r1_c4s5  <= fk_pkg::mulq(c4, s5);
        r1_s4s5  <= fk_pkg::mulq(s4, s5);
        r1_c1c23 <= fk_pkg::mulq(c1, c23);
        r1_c1s23 <= fk_pkg::mulq(c1, s23);
        r1_s1c23 <= fk_pkg::mulq(s1, c23);
        r1_s1s23 <= fk_pkg::mulq(s1, s23);
        r1_s4c5  <= fk_pkg::mulq(s4, c5);
        r1_c4c5  <= fk_pkg::mulq(c4, c5);
        r1_c4c6  <= fk_pkg::mulq(c4, c6);
        r1_s4c6  <= fk_pkg::mulq(s4, c6);
        r1_c4s6  <= fk_pkg::mulq(c4, s6);
        r1_s4s6  <= fk_pkg::mulq(s4, s6);
        r1_s2l2  <= fk_pkg::mulq(s2, fk_pkg::t_w'(i_l2));
        r1_c2l2  <= fk_pkg::mulq(c2, fk_pkg::t_w'(i_l2));
        r1_c23l3 <= fk_pkg::mulq(c23, fk_pkg::t_w'(i_l3));
        r1_s23l3 <= fk_pkg::mulq(s23, fk_pkg::t_w'(i_l3));
        r1_c1  <= c1;
        r1_s1  <= s1;
        r1_c23 <= c23;
        r1_s23 <= s23;
        r1_c5  <= c5;
        r1_c6  <= c6;
        r1_s6  <= s6;

        // S2: wrist triple products, third column terms, wrist offsets
        r2_u1   <= fk_pkg::mulq(r1_s4c5, r1_s6);
        r2_u2   <= fk_pkg::mulq(r1_c4c5, r1_s6);
        r2_u3   <= fk_pkg::mulq(r1_s4c5, r1_c6);
        r2_u4   <= fk_pkg::mulq(r1_c4c5, r1_c6);
        r2_p02a <= fk_pkg::mulq(r1_s1c23, r1_c4s5);
        r2_p02b <= fk_pkg::mulq(r1_c1, r1_s4s5);
        r2_p02c <= fk_pkg::mulq(r1_s1s23, r1_c5);
        r2_p12a <= fk_pkg::mulq(r1_c1c23, r1_c4s5);
        r2_p12b <= fk_pkg::mulq(r1_s1, r1_s4s5);
        r2_p12c <= fk_pkg::mulq(r1_c1s23, r1_c5);
        r2_p22a <= fk_pkg::mulq(r1_s23, r1_c4s5);
        r2_p22b <= fk_pkg::mulq(r1_c23, r1_c5);
        r2_dwv  <= r1_c2l2 + r1_c23l3;
        r2_dwh  <= -r1_s2l2 - r1_s23l3;
        r2_c4c6 <= r1_c4c6;
        r2_s4c6 <= r1_s4c6;
        r2_c4s6 <= r1_c4s6;
        r2_s4s6 <= r1_s4s6;
        r2_s1c23 <= r1_s1c23;
        r2_c1c23 <= r1_c1c23;
        r2_s1s23 <= r1_s1s23;
        r2_c1s23 <= r1_c1s23;
        r2_s5s6  <= r1_s5s6;
        r2_s5c6  <= r1_s5c6;
        r2_c1  <= r1_c1;
        r2_s1  <= r1_s1;
        r2_s23 <= r1_s23;
        r2_c23 <= r1_c23;

        // S3: wrist sums, third column, arm offset products
        r3_b0  <= r2_u1 - r2_c4c6;
        r3_a0  <= r2_u2 + r2_s4c6;
        r3_b1  <= r2_u3 + r2_c4s6;
        r3_a1  <= r2_u4 - r2_s4s6;
        r3_m02 <= fk_pkg::t_w'(fk_pkg::sat32(r2_p02a + r2_p02b + r2_p02c));
        r3_m12 <= fk_pkg::t_w'(fk_pkg::sat32(-r2_p12a + r2_p12b - r2_p12c));
        r3_m22 <= fk_pkg::t_w'(fk_pkg::sat32(-r2_p22a + r2_p22b));
        r3_ps0 <= fk_pkg::mulq(r2_s1, r2_dwh);
        r3_ps1 <= fk_pkg::mulq(r2_c1, r2_dwh);
        r3_dwv <= r2_dwv;
        r3_wb  <= r2_dwh[fk_pkg::WW-1];
        r3_s1c23 <= r2_s1c23;
        r3_c1c23 <= r2_c1c23;
        r3_s1s23 <= r2_s1s23;
        r3_c1s23 <= r2_c1s23;
        r3_s5s6  <= r2_s5s6;
        r3_s5c6  <= r2_s5c6;
        r3_c1  <= r2_c1;
        r3_s1  <= r2_s1;
        r3_s23 <= r2_s23;
        r3_c23 <= r2_c23;

        // S4: first two columns, tool offset
        r4_q00a <= fk_pkg::mulq(r3_s1c23, r3_a0);
        r4_q00b <= fk_pkg::mulq(r3_c1, r3_b0);
        r4_q00c <= fk_pkg::mulq(r3_s1s23, r3_s5s6);
        r4_q10a <= fk_pkg::mulq(r3_c1c23, r3_a0);
        r4_q10b <= fk_pkg::mulq(r3_s1, r3_b0);
        r4_q10c <= fk_pkg::mulq(r3_c1s23, r3_s5s6);
        r4_q20a <= fk_pkg::mulq(r3_s23, r3_a0);
        r4_q20b <= fk_pkg::mulq(r3_c23, r3_s5s6);
        r4_q01a <= fk_pkg::mulq(r3_s1c23, r3_a1);
        r4_q01b <= fk_pkg::mulq(r3_c1, r3_b1);
        r4_q01c <= fk_pkg::mulq(r3_s1s23, r3_s5c6);
        r4_q11a <= fk_pkg::mulq(r3_c1c23, r3_a1);
        r4_q11b <= fk_pkg::mulq(r3_s1, r3_b1);
        r4_q11c <= fk_pkg::mulq(r3_c1s23, r3_s5c6);
        r4_q21a <= fk_pkg::mulq(r3_s23, r3_a1);
        r4_q21b <= fk_pkg::mulq(r3_c23, r3_s5c6);
        r4_r0   <= fk_pkg::mulq(r3_m02, fk_pkg::t_w'(i_l6));
        r4_r1   <= fk_pkg::mulq(r3_m12, fk_pkg::t_w'(i_l6));
        r4_r2   <= fk_pkg::mulq(r3_m22, fk_pkg::t_w'(i_l6));
        r4_ps0  <= r3_ps0;
        r4_ps1  <= r3_ps1;
        r4_dwv  <= r3_dwv;
        r4_m02  <= r3_m02;
        r4_m12  <= r3_m12;
        r4_m22  <= r3_m22;
        r4_wb   <= r3_wb;

        // S5: result bank, held until the next item
        if (r4_meta.vld) begin
            r5_rows[0].c0  <= fk_pkg::sat32(-r4_q00a - r4_q00b + r4_q00c);
            r5_rows[1].c0  <= fk_pkg::sat32(r4_q10a - r4_q10b - r4_q10c);
            r5_rows[2].c0  <= fk_pkg::sat32(r4_q20a + r4_q20b);
            r5_rows[0].c1  <= fk_pkg::sat32(-r4_q01a - r4_q01b + r4_q01c);
            r5_rows[1].c1  <= fk_pkg::sat32(r4_q11a - r4_q11b - r4_q11c);
            r5_rows[2].c1  <= fk_pkg::sat32(r4_q21a + r4_q21b);
            r5_rows[0].c2  <= fk_pkg::t_q'(r4_m02);
            r5_rows[1].c2  <= fk_pkg::t_q'(r4_m12);
            r5_rows[2].c2  <= fk_pkg::t_q'(r4_m22);
            r5_rows[0].pos <= fk_pkg::sat32(r4_r0 - r4_ps0);
            r5_rows[1].pos <= fk_pkg::sat32(r4_r1 + r4_ps1);
            r5_rows[2].pos <= fk_pkg::sat32(r4_r2 + fk_pkg::t_w'(i_l1) + r4_dwv);
            r5_flags <= {r4_meta.elbow_dn, r4_meta.wrist_flip, r4_wb};
        end
    end

    // valid in the cycle before the bank loads, so row x goes out with the load
    assign o_vld   = r4_meta.vld;
    assign o_flags = r5_flags;
    assign o_rows  = r5_rows;

endmodule
`default_nettype wire

>>> bench/tb_six_axis_forward_kinematics.sv
`timescale 1ns / 100ps
module tb_six_axis_forward_kinematics;
    import fk_pkg::*;

    // pose flag bit positions
    localparam int FLAG_BEHIND = 0;
    localparam int FLAG_FLIP   = 1;
    localparam int FLAG_ELBOW  = 2;

    // Q.32 angle constants and CORDIC gain
    localparam longint PI_A      = 64'sd13493037705;
    localparam longint TWO_PI_A  = 64'sd26986075409;
    localparam longint HALF_PI_A = 64'sd6746518852;
    localparam longint QPI_A     = 64'sd3373259426;
    localparam longint GAIN_A    = 64'sd2608131496;
    localparam longint UNIT_Q30  = 64'sd1073741824;
    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint I32_MIN   = -64'sd2147483648;

    // angles in Q3.28
    localparam logic [31:0] ANG_PI   = 32'd843314857;
    localparam logic [31:0] ANG_HALF = 32'd421657428;

    localparam int WATCHDOG = 4000;
    localparam int DRAIN_CYCLES = CORDIC_STAGES + 20;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] pos;
        logic [2:0]  flags;
        logic        last;
    } row_t;

    typedef logic [31:0] angles_t [6];

    // directed stimulus; typed expectation for position and flags at zero lengths
    typedef struct {
        angles_t     ang;
        logic        typed;
        logic [2:0]  flags;
    } vec_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_wr = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic [31:0] i_joint_angle_1 = '0;
    logic [31:0] i_joint_angle_2 = '0;
    logic [31:0] i_joint_angle_3 = '0;
    logic [31:0] i_joint_angle_4 = '0;
    logic [31:0] i_joint_angle_5 = '0;
    logic [31:0] i_joint_angle_6 = '0;
    logic        o_strobe;
    logic [1:0]  o_row_index;
    logic [31:0] o_rot_col0;
    logic [31:0] o_rot_col1;
    logic [31:0] o_rot_col2;
    logic [31:0] o_position;
    logic [2:0]  o_pose_flags;
    logic        o_last_row;

    six_axis_forward_kinematics DUT (.*);

    always #2 i_clk = ~i_clk;

    // link lengths as the bench believes them
    logic [31:0] len_shoulder, len_upper, len_forearm, len_tool;
    longint      atan_tab [CORDIC_STAGES];
    row_t        pending_rows [$];
    // typed expectations for position/flags, one per pending row (valid bit first)
    logic [32:0] typed_rows [$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;

    // arctan(2^-i) in Q.32 via power series in Q.60
    function automatic longint arctan_q32(int i);
        longint acc;
        longint term;
        acc = 0;
        if (i == 0) return QPI_A;
        for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
            term = longint'((64'd1 << (60 - (2 * k + 1) * i)) / (2 * k + 1));
            acc = (k % 2) ? acc - term : acc + term;
        end
        return (acc + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint rq(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sext(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // rotation-mode CORDIC: angle Q.32 in, cos/sin Q1.30 out
    function automatic void cordic_sincos(input longint ang, output longint c,
                                          output longint s);
        longint x, y, z, nx, dx, dy;
        logic   flip;
        x = GAIN_A;
        y = 0;
        flip = 1'b0;
        while (ang > PI_A) ang -= TWO_PI_A;
        while (ang < -PI_A) ang += TWO_PI_A;
        if (ang > HALF_PI_A) begin
            ang -= PI_A;
            flip = 1'b1;
        end else if (ang < -HALF_PI_A) begin
            ang += PI_A;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                nx = x - dx; y = y + dy; z -= atan_tab[i];
            end else begin
                nx = x + dx; y = y - dy; z += atan_tab[i];
            end
            x = nx;
        end
        x = clip((x + 2) >>> 2, -UNIT_Q30, UNIT_Q30);
        y = clip((y + 2) >>> 2, -UNIT_Q30, UNIT_Q30);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // end-effector pose rows for one request
    task automatic predict_pose(input angles_t ang);
        longint q [6];
        longint c1, s1, c2, s2, c23, s23, c4, s4, c5, s5, c6, s6;
        longint s5c6, s5s6, c4s5, s4s5, c1c23, c1s23, s1c23, s1s23, a, b;
        longint m [3][3];
        longint p [3];
        longint dwv, dwh, l1, l2, l3, l6;
        logic [2:0] fl;
        row_t r;
        for (int j = 0; j < 6; j++) q[j] = sext(ang[j]);
        l1 = sext(len_shoulder);
        l2 = sext(len_upper);
        l3 = sext(len_forearm);
        l6 = sext(len_tool);
        cordic_sincos(q[0] * 16, c1, s1);
        cordic_sincos(q[1] * 16, c2, s2);
        cordic_sincos((q[1] + q[2]) * 16, c23, s23);
        cordic_sincos(q[3] * 16, c4, s4);
        cordic_sincos(q[4] * 16, c5, s5);
        cordic_sincos(q[5] * 16, c6, s6);
        s5c6 = rq(s5, c6);   s5s6 = rq(s5, s6);
        c4s5 = rq(c4, s5);   s4s5 = rq(s4, s5);
        c1c23 = rq(c1, c23); c1s23 = rq(c1, s23);
        s1c23 = rq(s1, c23); s1s23 = rq(s1, s23);

        b = rq(rq(s4, c5), s6) - rq(c4, c6);
        a = rq(rq(c4, c5), s6) + rq(s4, c6);
        m[0][0] = -rq(s1c23, a) - rq(c1, b) + rq(s1s23, s5s6);
        m[1][0] = rq(c1c23, a) - rq(s1, b) - rq(c1s23, s5s6);
        m[2][0] = rq(s23, a) + rq(c23, s5s6);

        b = rq(rq(s4, c5), c6) + rq(c4, s6);
        a = rq(rq(c4, c5), c6) - rq(s4, s6);
        m[0][1] = -rq(s1c23, a) - rq(c1, b) + rq(s1s23, s5c6);
        m[1][1] = rq(c1c23, a) - rq(s1, b) - rq(c1s23, s5c6);
        m[2][1] = rq(s23, a) + rq(c23, s5c6);

        m[0][2] = rq(s1c23, c4s5) + rq(c1, s4s5) + rq(s1s23, c5);
        m[1][2] = -rq(c1c23, c4s5) + rq(s1, s4s5) - rq(c1s23, c5);
        m[2][2] = -rq(s23, c4s5) + rq(c23, c5);

        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = clip(m[i][j], I32_MIN, I32_MAX);

        // wrist center, vertical and horizontal
        dwv = rq(c2, l2) + rq(c23, l3);
        dwh = -rq(s2, l2) - rq(s23, l3);
        p[0] = rq(m[0][2], l6) - rq(s1, dwh);
        p[1] = rq(m[1][2], l6) + rq(c1, dwh);
        p[2] = rq(m[2][2], l6) + l1 + dwv;

        fl = '0;
        fl[FLAG_BEHIND] = dwh < 0;
        fl[FLAG_FLIP]   = q[4] < 0;
        fl[FLAG_ELBOW]  = q[2] < 0;

        for (int i = 0; i < 3; i++) begin
            r.row   = 2'(i);
            r.c0    = 32'(m[i][0]);
            r.c1    = 32'(m[i][1]);
            r.c2    = 32'(m[i][2]);
            r.pos   = 32'(clip(p[i], I32_MIN, I32_MAX));
            r.flags = fl;
            r.last  = (2'(i) == ROW_Z);
            pending_rows.push_back(r);
        end
    endtask

    task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
    endtask

    // result monitor: outputs sampled before this edge's updates
    always @(posedge i_clk) begin
        row_t       e;
        logic [32:0] t;
        if (i_rst_n && o_strobe) begin
            if (pending_rows.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, row %0d", $time, o_row_index);
            end else begin
                e = pending_rows.pop_front();
                t = typed_rows.pop_front();
                if (o_row_index !== e.row) report("row_index", e.row, o_row_index);
                if (o_rot_col0 !== e.c0) report("rot_col0", e.c0, o_rot_col0);
                if (o_rot_col1 !== e.c1) report("rot_col1", e.c1, o_rot_col1);
                if (o_rot_col2 !== e.c2) report("rot_col2", e.c2, o_rot_col2);
                if (o_position !== e.pos) report("position", e.pos, o_position);
                if (o_pose_flags !== e.flags) report("pose_flags", e.flags, o_pose_flags);
                if (o_last_row !== e.last) report("last_row", e.last, o_last_row);
                // hand-typed: zero lengths give zero position
                if (t[32] && o_position !== 32'd0) report("position(typed)", 0, o_position);
                if (t[32] && o_pose_flags !== t[2:0])
                    report("pose_flags(typed)", t[2:0], o_pose_flags);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            timed_out <= 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // present a request and hold it until taken
    task automatic send_request(input angles_t ang, input logic typed, input logic [2:0] fl);
        start           <= 1'b1;
        i_joint_angle_1 <= ang[0];
        i_joint_angle_2 <= ang[1];
        i_joint_angle_3 <= ang[2];
        i_joint_angle_4 <= ang[3];
        i_joint_angle_5 <= ang[4];
        i_joint_angle_6 <= ang[5];
        do @(posedge i_clk); while (busy);
        predict_pose(ang);
        repeat (3) typed_rows.push_back({typed, 29'd0, fl});
    endtask

    task automatic sender_gap();
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lengths(input logic [31:0] sh, up, fo, tl);
        logic [31:0] vals [4];
        vals = '{sh, up, fo, tl};
        for (int i = 0; i < 4; i++) begin
            i_cfg_wr   <= 1'b1;
            i_cfg_addr <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr <= 1'b0;
        len_shoulder = sh;
        len_upper    = up;
        len_forearm  = fo;
        len_tool     = tl;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2:    return 32'($signed($urandom_range(0, 2 * ANG_PI)) - $signed(ANG_PI));
            3:    return ($urandom_range(0, 1) ? ANG_PI : -ANG_PI) + 32'($urandom_range(0, 8)) - 4;
            4:    return ($urandom_range(0, 1) ? ANG_HALF : -ANG_HALF) + 32'($urandom_range(0, 8)) - 4;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
        endcase
    endfunction

    vec_t directed [$];

    function automatic vec_t mk(logic [31:0] a1, a2, a3, a4, a5, a6, logic typed);
        vec_t v;
        v.ang   = '{a1, a2, a3, a4, a5, a6};
        v.typed = typed;
        v.flags = {a3[31], a5[31], 1'b0};
        return v;
    endfunction

    initial begin
        angles_t ang;
        for (int i = 0; i < CORDIC_STAGES; i++) atan_tab[i] = arctan_q32(i);
        len_shoulder = 0; len_upper = 0; len_forearm = 0; len_tool = 0;

        directed.push_back(mk(0, 0, 0, 0, 0, 0, 1));
        directed.push_back(mk('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, 1));
        directed.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h80000000, 1));
        directed.push_back(mk(ANG_PI, ANG_PI, 0, ANG_PI, ANG_PI, ANG_PI, 1));
        directed.push_back(mk(-ANG_PI, -ANG_PI, 0, -ANG_PI, -ANG_PI, -ANG_PI, 1));
        directed.push_back(mk(ANG_HALF, ANG_HALF, ANG_HALF, ANG_HALF, ANG_HALF, ANG_HALF, 1));
        directed.push_back(mk(-ANG_HALF, 0, -ANG_HALF, -ANG_HALF, -ANG_HALF, -ANG_HALF, 1));
        directed.push_back(mk(0, 0, -1, 0, 0, 0, 1));
        directed.push_back(mk(0, 0, 0, 0, -1, 0, 1));
        directed.push_back(mk(1, 1, 1, 1, 1, 1, 1));
        directed.push_back(mk(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 1));
        directed.push_back(mk(ANG_PI + 1, ANG_HALF + 1, -ANG_HALF - 1, 0, 1, -1, 1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset lengths
        foreach (directed[k]) begin
            send_request(directed[k].ang, directed[k].typed, directed[k].flags);
            sender_gap();
        end
        drain();

        // length phases: extremes, then random and realistic ones
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_lengths(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                1: write_lengths(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
                2: write_lengths(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
                3: write_lengths(32'h00010000, 32'h00008000, 32'h00006000, 32'h00001800);
                default: write_lengths(rand_len(), rand_len(), rand_len(), rand_len());
            endcase
            for (int n = 0; n < 64; n++) begin
                foreach (ang[j]) ang[j] = rand_angle();
                send_request(ang, 1'b0, 3'd0);
                // one burst stretch per phase with no sender idling
                if (n < 16 || n >= 32) sender_gap();
                if (ph == 3 && n == 40) drain();
            end
            drain();
        end

        if (errors == 0 && !timed_out) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fk_pkg.sv
rtl/fk_prep.sv
rtl/fk_cordic_cell.sv
rtl/fk_pose.sv
rtl/six_axis_forward_kinematics.sv
bench/tb_six_axis_forward_kinematics.sv
